FILE: rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, constants and helpers of the buddy block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

   localparam int MIN_ORDER    = 5;
   localparam int ORDER_LIMIT  = 16;
   localparam int HEADER_BYTES = 16;

   localparam int NORD      = ORDER_LIMIT - MIN_ORDER + 1;
   localparam int GRANULES  = 1 << (ORDER_LIMIT - MIN_ORDER);
   localparam int GRAN_W    = ORDER_LIMIT - MIN_ORDER;
   localparam int STK_CELLS = 2 * GRANULES;
   localparam int STK_AW    = GRAN_W + 1;
   localparam int DEPTH_W   = GRAN_W + 1;
   localparam int IDX_W     = $clog2(NORD);
   localparam int ORD_W     = 5;
   localparam int BYTE_W    = ORDER_LIMIT + 1;
   localparam int OFF_W     = 16;
   localparam int CNT_W     = 32;

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_NOSPACE = 2'd1,
      STAT_BADFREE = 2'd2
   } status_type;

   typedef struct packed {
      logic             start;
      logic             used;
      logic [ORD_W-1:0] order;
   } tag_type;

   typedef struct packed {
      logic              rebuild;
      logic              clear;
      logic              alloc_ok;
      logic              alloc_fail;
      logic              free_ok;
      logic [BYTE_W-1:0] bytes;
   } stat_op_type;

   typedef struct packed {
      logic [BYTE_W-1:0] in_use;
      logic [BYTE_W-1:0] peak;
      logic [CNT_W-1:0]  allocs;
      logic [CNT_W-1:0]  frees;
      logic [CNT_W-1:0]  fails;
   } stat_val_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [OFF_W-1:0] offset;
      logic [ORD_W-1:0] order;
   } result_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_A_ORD,
      ST_A_FIND,
      ST_A_POP,
      ST_A_SPLIT,
      ST_F_TAG,
      ST_F_MRG,
      ST_F_BT,
      ST_T_RD,
      ST_T_CMP,
      ST_S_RD,
      ST_S_WR,
      ST_M_ZERO,
      ST_M_SET,
      ST_F_PUSH,
      ST_OUT
   } state_type;

   function automatic logic [IDX_W-1:0] ord_idx(input logic [ORD_W-1:0] k);
      return IDX_W'(k - ORD_W'(MIN_ORDER));
   endfunction

   function automatic logic [STK_AW-1:0] stack_base(input logic [ORD_W-1:0] k);
      logic [STK_AW:0] one_hot;
      one_hot = (STK_AW+1)'(1) << (ORD_W'(ORDER_LIMIT) - k);
      return STK_AW'(one_hot - (STK_AW+1)'(1));
   endfunction

   function automatic logic [GRAN_W-1:0] gran_pow(input logic [ORD_W-1:0] k);
      return GRAN_W'(1) << (k - ORD_W'(MIN_ORDER));
   endfunction

   function automatic logic [BYTE_W-1:0] byte_pow(input logic [ORD_W-1:0] k);
      return BYTE_W'(1) << k;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/bba_stats.sv
// ----------------------------------------------------------------------------
// bba_stats
// In-use and peak byte counts and the allocation counters.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_stats (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bba_pkg::stat_op_type op,
   output bba_pkg::stat_val_type     val
);
   import bba_pkg::*;

   stat_val_type val_ff, val_in;
   logic [BYTE_W-1:0] sum;

   always_comb begin
      val_in = val_ff;
      sum    = val_ff.in_use + op.bytes;
      if (op.rebuild) begin
         val_in = '0;
      end else if (op.clear) begin
         val_in.allocs = '0;
         val_in.frees  = '0;
         val_in.fails  = '0;
         val_in.peak   = val_ff.in_use;
      end else if (op.alloc_ok) begin
         val_in.in_use = sum;
         val_in.allocs = val_ff.allocs + CNT_W'(1);
         if (sum > val_ff.peak) begin
            val_in.peak = sum;
         end
      end else if (op.alloc_fail) begin
         val_in.fails = val_ff.fails + CNT_W'(1);
      end else if (op.free_ok) begin
         val_in.in_use = val_ff.in_use - op.bytes;
         val_in.frees  = val_ff.frees + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
      end else begin
         val_ff <= val_in;
      end
   end

   assign val = val_ff;

endmodule

`default_nettype wire

FILE: rtl/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer over the free stacks and granule tags: search, split, merge.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_we,
   input  wire logic [bba_pkg::ORD_W-1:0]   csr_data,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire logic [1:0]                  in_cmd,
   input  wire logic [bba_pkg::OFF_W-1:0]   in_bytes,
   input  wire logic [bba_pkg::OFF_W-1:0]   in_rel,
   input  wire logic                        out_free,
   output logic                             res_valid,
   output bba_pkg::result_type              res,
   output bba_pkg::stat_op_type             stat_op
);
   import bba_pkg::*;

   state_type state_ff, state_in;
   logic [ORD_W-1:0]   arena_ff, arena_in;
   logic [BYTE_W-1:0]  need_ff, need_in;
   logic [ORD_W-1:0]   ord_ff, ord_in;
   logic [ORD_W-1:0]   cur_ff, cur_in;
   logic [GRAN_W-1:0]  g_ff, g_in;
   logic [GRAN_W-1:0]  b_ff, b_in;
   logic [DEPTH_W-1:0] j_ff, j_in;
   logic [GRAN_W-1:0]  clr_ff, clr_in;
   logic [DEPTH_W-1:0] depth_ff [NORD];
   logic [DEPTH_W-1:0] depth_in [NORD];
   result_type         res_ff, res_in;

   logic                t_we;
   logic [GRAN_W-1:0]   t_waddr, t_raddr;
   tag_type             t_wdata, t_rdata;
   logic                s_we;
   logic [STK_AW-1:0]   s_waddr, s_raddr;
   logic [GRAN_W-1:0]   s_wdata, s_rdata;

   logic [DEPTH_W-1:0]  dcur;
   logic [ORD_W-1:0]    cm1;
   logic [ORD_W-1:0]    csr_val;
   logic [OFF_W-1:0]    reqv, blk;
   logic [GRAN_W-1:0]   bud;

   bba_ram #(.WIDTH($bits(tag_type)), .DEPTH(GRANULES)) u_tag (
      .clock   (clock),
      .wr_en   (t_we),
      .wr_addr (t_waddr),
      .wr_data (t_wdata),
      .rd_addr (t_raddr),
      .rd_data (t_rdata)
   );

   bba_ram #(.WIDTH(GRAN_W), .DEPTH(STK_CELLS)) u_stack (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_addr (s_raddr),
      .rd_data (s_rdata)
   );

   always_comb begin
      state_in  = state_ff;
      arena_in  = arena_ff;
      need_in   = need_ff;
      ord_in    = ord_ff;
      cur_in    = cur_ff;
      g_in      = g_ff;
      b_in      = b_ff;
      j_in      = j_ff;
      clr_in    = clr_ff;
      depth_in  = depth_ff;
      res_in    = res_ff;
      in_ready  = 1'b0;
      res_valid = 1'b0;
      stat_op   = '0;
      t_we      = 1'b0;
      t_waddr   = g_ff;
      t_wdata   = '0;
      t_raddr   = g_ff;
      s_we      = 1'b0;
      s_waddr   = '0;
      s_wdata   = g_ff;
      s_raddr   = '0;
      dcur      = depth_ff[ord_idx(cur_ff)];
      cm1       = cur_ff - ORD_W'(1);
      bud       = g_ff + gran_pow(cm1);
      reqv      = (in_bytes == '0) ? OFF_W'(1) : in_bytes;
      blk       = in_rel - OFF_W'(HEADER_BYTES);
      csr_val   = csr_data;

      unique case (state_ff)
         ST_CLEAR: begin
            t_we    = 1'b1;
            t_waddr = clr_ff;
            if (clr_ff == '0) begin
               t_wdata = '{start: 1'b1, used: 1'b0, order: arena_ff};
               s_we    = 1'b1;
               s_waddr = stack_base(arena_ff);
               s_wdata = '0;
            end
            clr_in = clr_ff + GRAN_W'(1);
            if (clr_ff == GRAN_W'(GRANULES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               res_in = '{status: STAT_OK, offset: '0, order: '0};
               unique case (in_cmd)
                  CMD_ALLOC: begin
                     need_in  = BYTE_W'(reqv) + BYTE_W'(HEADER_BYTES);
                     ord_in   = ORD_W'(MIN_ORDER);
                     state_in = ST_A_ORD;
                  end
                  CMD_FREE: begin
                     if (in_rel < OFF_W'(HEADER_BYTES) || blk[MIN_ORDER-1:0] != '0 ||
                         BYTE_W'(blk) >= byte_pow(arena_ff)) begin
                        res_in.status = STAT_BADFREE;
                        state_in      = ST_OUT;
                     end else begin
                        g_in     = GRAN_W'(blk >> MIN_ORDER);
                        t_raddr  = GRAN_W'(blk >> MIN_ORDER);
                        state_in = ST_F_TAG;
                     end
                  end
                  CMD_CLEAR: begin
                     stat_op.clear = 1'b1;
                     state_in      = ST_OUT;
                  end
                  default: begin
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_A_ORD: begin
            if (need_ff > byte_pow(arena_ff)) begin
               res_in.status      = STAT_NOSPACE;
               stat_op.alloc_fail = 1'b1;
               state_in           = ST_OUT;
            end else if (byte_pow(ord_ff) < need_ff) begin
               ord_in = ord_ff + ORD_W'(1);
            end else begin
               cur_in   = ord_ff;
               state_in = ST_A_FIND;
            end
         end
         ST_A_FIND: begin
            if (cur_ff > arena_ff) begin
               res_in.status      = STAT_NOSPACE;
               stat_op.alloc_fail = 1'b1;
               state_in           = ST_OUT;
            end else if (dcur != '0) begin
               depth_in[ord_idx(cur_ff)] = dcur - DEPTH_W'(1);
               s_raddr  = stack_base(cur_ff) + STK_AW'(dcur - DEPTH_W'(1));
               state_in = ST_A_POP;
            end else begin
               cur_in = cur_ff + ORD_W'(1);
            end
         end
         ST_A_POP: begin
            g_in     = s_rdata;
            state_in = ST_A_SPLIT;
         end
         ST_A_SPLIT: begin
            t_we = 1'b1;
            if (cur_ff > ord_ff) begin
               t_waddr = bud;
               t_wdata = '{start: 1'b1, used: 1'b0, order: cm1};
               s_we    = 1'b1;
               s_waddr = stack_base(cm1) + STK_AW'(depth_ff[ord_idx(cm1)]);
               s_wdata = bud;
               depth_in[ord_idx(cm1)] = depth_ff[ord_idx(cm1)] + DEPTH_W'(1);
               cur_in  = cm1;
            end else begin
               t_waddr          = g_ff;
               t_wdata          = '{start: 1'b1, used: 1'b1, order: ord_ff};
               stat_op.alloc_ok = 1'b1;
               stat_op.bytes    = byte_pow(ord_ff);
               res_in.offset    = (OFF_W'(g_ff) << MIN_ORDER) + OFF_W'(HEADER_BYTES);
               res_in.order     = ord_ff;
               state_in         = ST_OUT;
            end
         end
         ST_F_TAG: begin
            if (!t_rdata.start || !t_rdata.used || t_rdata.order < ORD_W'(MIN_ORDER) ||
                t_rdata.order > arena_ff) begin
               res_in.status = STAT_BADFREE;
               state_in      = ST_OUT;
            end else begin
               cur_in          = t_rdata.order;
               res_in.order    = t_rdata.order;
               stat_op.free_ok = 1'b1;
               stat_op.bytes   = byte_pow(t_rdata.order);
               t_we            = 1'b1;
               t_waddr         = g_ff;
               t_wdata         = '{start: 1'b1, used: 1'b0, order: t_rdata.order};
               state_in        = ST_F_MRG;
            end
         end
         ST_F_MRG: begin
            if (cur_ff < arena_ff) begin
               b_in     = g_ff ^ gran_pow(cur_ff);
               t_raddr  = g_ff ^ gran_pow(cur_ff);
               state_in = ST_F_BT;
            end else begin
               state_in = ST_F_PUSH;
            end
         end
         ST_F_BT: begin
            if (!t_rdata.start || t_rdata.used || t_rdata.order != cur_ff) begin
               state_in = ST_F_PUSH;
            end else begin
               j_in     = '0;
               state_in = ST_T_RD;
            end
         end
         ST_T_RD: begin
            if (j_ff < dcur) begin
               s_raddr  = stack_base(cur_ff) + STK_AW'(j_ff);
               state_in = ST_T_CMP;
            end else begin
               state_in = ST_F_PUSH;
            end
         end
         ST_T_CMP: begin
            if (s_rdata == b_ff) begin
               state_in = ST_S_RD;
            end else begin
               j_in     = j_ff + DEPTH_W'(1);
               state_in = ST_T_RD;
            end
         end
         ST_S_RD: begin
            if (j_ff + DEPTH_W'(1) < dcur) begin
               s_raddr  = stack_base(cur_ff) + STK_AW'(j_ff + DEPTH_W'(1));
               state_in = ST_S_WR;
            end else begin
               depth_in[ord_idx(cur_ff)] = dcur - DEPTH_W'(1);
               state_in = ST_M_ZERO;
            end
         end
         ST_S_WR: begin
            s_we     = 1'b1;
            s_waddr  = stack_base(cur_ff) + STK_AW'(j_ff);
            s_wdata  = s_rdata;
            j_in     = j_ff + DEPTH_W'(1);
            state_in = ST_S_RD;
         end
         ST_M_ZERO: begin
            t_we    = 1'b1;
            t_wdata = '0;
            if (b_ff < g_ff) begin
               t_waddr = g_ff;
               g_in    = b_ff;
            end else begin
               t_waddr = b_ff;
            end
            cur_in   = cur_ff + ORD_W'(1);
            state_in = ST_M_SET;
         end
         ST_M_SET: begin
            t_we     = 1'b1;
            t_waddr  = g_ff;
            t_wdata  = '{start: 1'b1, used: 1'b0, order: cur_ff};
            state_in = ST_F_MRG;
         end
         ST_F_PUSH: begin
            s_we    = 1'b1;
            s_waddr = stack_base(cur_ff) + STK_AW'(dcur);
            s_wdata = g_ff;
            depth_in[ord_idx(cur_ff)] = dcur + DEPTH_W'(1);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               res_valid = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         if (csr_val < ORD_W'(MIN_ORDER)) begin
            csr_val = ORD_W'(MIN_ORDER);
         end else if (csr_val > ORD_W'(ORDER_LIMIT)) begin
            csr_val = ORD_W'(ORDER_LIMIT);
         end
         arena_in        = csr_val;
         state_in        = ST_CLEAR;
         clr_in          = '0;
         stat_op         = '0;
         stat_op.rebuild = 1'b1;
         for (int i = 0; i < NORD; i++) begin
            depth_in[i] = '0;
         end
         depth_in[ord_idx(csr_val)] = DEPTH_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         arena_ff <= ORD_W'(ORDER_LIMIT);
         clr_ff   <= '0;
         for (int i = 0; i < NORD; i++) begin
            depth_ff[i] <= (i == NORD - 1) ? DEPTH_W'(1) : '0;
         end
      end else begin
         state_ff <= state_in;
         arena_ff <= arena_in;
         clr_ff   <= clr_in;
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      need_ff <= need_in;
      ord_ff  <= ord_in;
      cur_ff  <= cur_in;
      g_ff    <= g_in;
      b_ff    <= b_in;
      j_ff    <= j_in;
      res_ff  <= res_in;
   end

   assign res = res_ff;

endmodule

`default_nettype wire

FILE: rtl/buddy_block_allocator_top.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator_top
// Binary buddy allocator over a power-of-two arena with usage statistics.
// ----------------------------------------------------------------------------
// One item at a time. After reset and after every arena order write the tag
// store is swept before the first item is taken. An allocate steps up through
// the orders in its size search, scans the orders upward for a free block and
// then splits it down to the order needed; one that is too large is rejected.
// A free marks its tag free and then, per merge level, scans the free stack
// for the buddy and moves the entries above it down to close the gap, one
// entry at a time through the single read port of the free stack memory; a
// buddy that cannot merge ends the merging and the block is pushed. A rejected
// free and a clear statistics item only give a result. The result register
// lets the next item in while a result waits.
`default_nettype none

module buddy_block_allocator_top (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_we,
   input  wire logic [4:0]    csr_data,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [31:0]   req_tdata,   // request_bytes, release_offset
   input  wire logic [1:0]    req_tuser,   // command
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic      [151:0]  rsp_tdata,   // granted_offset, granted_order,
                                           // in_use_bytes, peak_bytes, alloc_count,
                                           // free_count, failure_count, zero pad
   output logic      [1:0]    rsp_tuser    // status
);
   import bba_pkg::*;

   logic         out_free;
   logic         res_valid;
   result_type   res;
   stat_op_type  stat_op;
   stat_val_type stat_val;

   logic         rsp_valid_ff;
   result_type   rsp_res_ff;
   stat_val_type rsp_stat_ff;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_data  (csr_data),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (req_tuser),
      .in_bytes  (req_tdata[15:0]),
      .in_rel    (req_tdata[31:16]),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res       (res),
      .stat_op   (stat_op)
   );

   bba_stats u_stats (
      .clock (clock),
      .reset (reset),
      .op    (stat_op),
      .val   (stat_val)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_res_ff  <= res;
         rsp_stat_ff <= stat_val;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_res_ff.status;
   assign rsp_tdata  = {1'b0, rsp_stat_ff.fails, rsp_stat_ff.frees, rsp_stat_ff.allocs,
                        rsp_stat_ff.peak, rsp_stat_ff.in_use, rsp_res_ff.order,
                        rsp_res_ff.offset};

endmodule

`default_nettype wire
